// ===== hdl/rc4_pkg.sv =====
package rc4_pkg;

	// key length in bytes; key bytes beyond this are ignored
	localparam int KEY_BYTES = 16;
	localparam int KIDX_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

	// permutation table geometry
	localparam int PERM_DEPTH = 256;
	localparam int BYTE_W = 8;

	// configuration port
	localparam int CFG_ADDR_W = 1;
	localparam int CFG_DATA_W = 64;
	localparam logic [CFG_ADDR_W-1:0] CFG_KEY_LOW = 1'b0;
	localparam logic [CFG_ADDR_W-1:0] CFG_KEY_HIGH = 1'b1;

	// item modes
	localparam logic MODE_KEY = 1'b0;
	localparam logic MODE_DATA = 1'b1;

	typedef struct packed {
		logic mode;
		logic [7:0] data_in;
	} cmd_t;

	typedef struct packed {
		logic [7:0] data_out;
		logic [7:0] stream_byte;
		logic keyed;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FILL,
		ST_KS_RD,
		ST_KS_J,
		ST_KS_WA,
		ST_KS_WB,
		ST_DT_J,
		ST_DT_SJ,
		ST_DT_WB,
		ST_PUSH
	} state_t;

endpackage

// ===== hdl/rc4_ram.sv =====
module rc4_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port, read returns old data on a collision
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hdl/rc4_keystream_cipher_unit.sv =====
// RC4 keystream cipher unit.
// cmd channel (cmd_valid/cmd_ready, cmd): one item per handshake. A key item
// (mode 0) loads the permutation with the identity and scrambles it with the
// key held in the two key registers, then clears i and j and sets keyed. A
// data item (mode 1) advances i and j, swaps the two entries and returns the
// data byte xor the keystream byte.
// rsp channel (rsp_valid/rsp_ready, rsp): exactly one result per cmd item.
// cfg port: cfg_we writes cfg_data to key_low (addr 0) or key_high (addr 1);
// write only while the unit is idle.
// A data item before any key goes straight to the push. A key item fills the
// table, then runs a scramble step per entry (read, index update, two
// writes), then the push. The permutation RAM has one write and one read
// port: each data byte takes two dependent reads, a keystream read and two
// write-backs.
// The unit takes one item at a time; cmd_ready is high in idle, which is
// entered again as soon as the result moves into the output register.
// A stalled receiver holds the result in the output register; a new item can
// be accepted meanwhile, and its result waits until the register frees up.
// Reset clears i, j, keyed, the key registers and all handshakes. The
// permutation RAM is not cleared; data before a key passes through untouched.
module rc4_keystream_cipher_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cmd_valid,
	output logic                               cmd_ready,
	input  rc4_pkg::cmd_t                      cmd,
	output logic                               rsp_valid,
	input  logic                               rsp_ready,
	output rc4_pkg::rsp_t                      rsp,
	input  logic                               cfg_we,
	input  logic [rc4_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [rc4_pkg::CFG_DATA_W-1:0]     cfg_data
);

	import rc4_pkg::*;

	localparam int AW = $clog2(PERM_DEPTH);

	state_t state_q, state_d;

	logic [CFG_DATA_W-1:0] key_low_q, key_high_q;
	logic [AW-1:0]         i_q, j_q, cnt_q;
	logic [KIDX_W-1:0]     kidx_q;
	logic                  keyed_q;
	logic [BYTE_W-1:0]     si_q, sj_q;
	logic                  fwd_i_q, fwd_j_q;
	rsp_t                  res_q;
	logic                  rsp_valid_q;
	rsp_t                  rsp_q;

	logic                  ram_we, ram_re;
	logic [AW-1:0]         ram_waddr, ram_raddr;
	logic [BYTE_W-1:0]     ram_wdata, ram_rdata;

	logic                  accept, push;
	logic [2*CFG_DATA_W-1:0] key_all;
	logic [BYTE_W-1:0]     key_byte;
	logic [AW-1:0]         i_next, j_data, j_key, t_addr;
	logic [BYTE_W-1:0]     ks_byte;

	rc4_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(PERM_DEPTH)
	) u_perm (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign cmd_ready = (state_q == ST_IDLE);
	assign accept = cmd_valid && cmd_ready;
	assign push = (state_q == ST_PUSH) && (!rsp_valid_q || rsp_ready);
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	// index arithmetic, all modulo the table depth
	assign key_all = {key_high_q, key_low_q};
	assign key_byte = key_all[{kidx_q, 3'b000} +: BYTE_W];
	assign i_next = i_q + AW'(1);
	assign j_data = j_q + ram_rdata;
	assign j_key = j_q + ram_rdata + key_byte;
	assign t_addr = si_q + ram_rdata;

	// keystream byte, forwarded where the read hits a swapped entry
	always_comb begin
		priority if (fwd_j_q) begin
			ks_byte = si_q;
		end else if (fwd_i_q) begin
			ks_byte = sj_q;
		end else begin
			ks_byte = ram_rdata;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (cmd.mode == MODE_KEY) begin
						state_d = ST_FILL;
					end else if (keyed_q) begin
						state_d = ST_DT_J;
					end else begin
						state_d = ST_PUSH;
					end
				end
			end
			ST_FILL: begin
				if (cnt_q == AW'(PERM_DEPTH - 1)) begin
					state_d = ST_KS_RD;
				end
			end
			ST_KS_RD: state_d = ST_KS_J;
			ST_KS_J:  state_d = ST_KS_WA;
			ST_KS_WA: state_d = ST_KS_WB;
			ST_KS_WB: begin
				if (cnt_q == AW'(PERM_DEPTH - 1)) begin
					state_d = ST_PUSH;
				end else begin
					state_d = ST_KS_RD;
				end
			end
			ST_DT_J:  state_d = ST_DT_SJ;
			ST_DT_SJ: state_d = ST_DT_WB;
			ST_DT_WB: state_d = ST_PUSH;
			ST_PUSH: begin
				if (push) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// memory port control
	always_comb begin
		ram_we = 1'b0;
		ram_waddr = cnt_q;
		ram_wdata = cnt_q;
		ram_re = 1'b0;
		ram_raddr = cnt_q;
		unique case (state_q)
			ST_IDLE: begin
				// fetch S[i+1] as a data item comes in
				ram_re = accept && (cmd.mode == MODE_DATA) && keyed_q;
				ram_raddr = i_next;
			end
			ST_FILL: begin
				ram_we = 1'b1;
			end
			ST_KS_RD: begin
				ram_re = 1'b1;
			end
			ST_KS_J: begin
				ram_re = 1'b1;
				ram_raddr = j_key;
			end
			ST_KS_WA: begin
				ram_we = 1'b1;
				ram_wdata = ram_rdata;
			end
			ST_KS_WB: begin
				ram_we = 1'b1;
				ram_waddr = j_q;
				ram_wdata = si_q;
			end
			ST_DT_J: begin
				ram_re = 1'b1;
				ram_raddr = j_data;
			end
			ST_DT_SJ: begin
				ram_we = 1'b1;
				ram_waddr = i_q;
				ram_wdata = ram_rdata;
				ram_re = 1'b1;
				ram_raddr = t_addr;
			end
			ST_DT_WB: begin
				ram_we = 1'b1;
				ram_waddr = j_q;
				ram_wdata = si_q;
			end
			ST_PUSH: begin
			end
			default: begin
			end
		endcase
	end

	// state and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q <= '0;
			j_q <= '0;
			cnt_q <= '0;
			kidx_q <= '0;
			keyed_q <= 1'b0;
			key_low_q <= '0;
			key_high_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			// configuration writes
			if (cfg_we) begin
				unique case (cfg_addr)
					CFG_KEY_LOW:  key_low_q <= cfg_data;
					CFG_KEY_HIGH: key_high_q <= cfg_data;
					default: begin
					end
				endcase
			end

			// index and counter updates
			unique case (state_q)
				ST_IDLE: begin
					if (accept && cmd.mode == MODE_KEY) begin
						cnt_q <= '0;
						kidx_q <= '0;
						j_q <= '0;
					end else if (accept && keyed_q) begin
						i_q <= i_next;
					end
				end
				ST_FILL: cnt_q <= cnt_q + AW'(1);
				ST_KS_J: j_q <= j_key;
				ST_KS_WB: begin
					cnt_q <= cnt_q + AW'(1);
					kidx_q <= (kidx_q == KIDX_W'(KEY_BYTES - 1)) ? '0 : kidx_q + KIDX_W'(1);
					if (cnt_q == AW'(PERM_DEPTH - 1)) begin
						i_q <= '0;
						j_q <= '0;
						keyed_q <= 1'b1;
					end
				end
				ST_DT_J: j_q <= j_data;
				default: begin
				end
			endcase

			// output register
			if (push) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				res_q.data_out <= cmd.data_in;
				res_q.stream_byte <= '0;
				res_q.keyed <= keyed_q;
			end
			ST_KS_J: si_q <= ram_rdata;
			ST_KS_WB: begin
				res_q.data_out <= '0;
				res_q.stream_byte <= '0;
				res_q.keyed <= 1'b1;
			end
			ST_DT_J: si_q <= ram_rdata;
			ST_DT_SJ: begin
				sj_q <= ram_rdata;
				fwd_i_q <= (t_addr == i_q);
				fwd_j_q <= (t_addr == j_q);
			end
			ST_DT_WB: begin
				res_q.data_out <= res_q.data_out ^ ks_byte;
				res_q.stream_byte <= ks_byte;
			end
			default: begin
			end
		endcase
		if (push) begin
			rsp_q <= res_q;
		end
	end

endmodule

// ===== hdl/rc4_chk.sv =====
module rc4_chk (
	input logic          clk,
	input logic          arst_n,
	input logic          cmd_valid,
	input logic          cmd_ready,
	input rc4_pkg::cmd_t cmd,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input rc4_pkg::rsp_t rsp
);

	import rc4_pkg::*;

	// a stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	// one item at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("item accepted while busy");

	// a key item keeps the unit busy, with no rising result, once the fill has begun
	a_key_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && cmd.mode == MODE_KEY |=> ##1 !cmd_ready && !$rose(rsp_valid))
		else $error("key schedule ended too early");

	// no keystream without a key
	a_no_key_ks: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.keyed |-> rsp.stream_byte == '0)
		else $error("keystream byte before any key schedule");

endmodule

bind rc4_keystream_cipher_unit rc4_chk u_rc4_chk (.*);
